// ----- sv/boe_pkg.sv -----
// Shared types and constants for the bounded ordered list engine.
// Used by boe_ctrl, boe_datapath and the top level; no dependencies.
package boe_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int DATA_WIDTH  = 32;

	// Field widths fixed by the stream format
	localparam int OP_W   = 3;
	localparam int POS_W  = 5;
	localparam int CAP_W  = 5;
	localparam int CNTO_W = 5;
	localparam int ST_W   = 2;

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CMP_A = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int CMP_W = (CMP_A > CAP_W) ? CMP_A : CAP_W;

	localparam int IN_BITS   = POS_W + DATA_WIDTH;
	localparam int IN_TDATA  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS  = DATA_WIDTH + CNTO_W;
	localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND      = 3'd0,
		OP_REMOVE_LAST = 3'd1,
		OP_INSERT      = 3'd2,
		OP_DELETE      = 3'd3,
		OP_READ        = 3'd4
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_DONE    = 2'd0,
		ST_BAD_POS = 2'd1,
		ST_FULL    = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_in;  // capture the incoming item
		logic exec;     // apply the held item and load the result register
	} boe_cmd_t;

endpackage

// ----- sv/boe_ctrl.sv -----
// Controller for the bounded ordered list engine: input/output handshake
// and sequencing of one item at a time. Depends on boe_pkg.
module boe_ctrl import boe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output boe_cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign cmd.load_in = in_valid && in_ready;
	// Apply only when the result register is free or drains this cycle
	assign cmd.exec    = (state_q == S_EXEC) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load_in) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd.exec) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- sv/boe_datapath.sv -----
// Datapath for the bounded ordered list engine: input register, chain of
// entry cells with parallel shift, count, capacity register and result register.
// Depends on boe_pkg.
module boe_datapath import boe_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  boe_cmd_t              cmd,
	input  logic [OP_W-1:0]       in_opcode,
	input  logic [POS_W-1:0]      in_position,
	input  logic [DATA_WIDTH-1:0] in_value,
	input  logic                  cap_we,
	input  logic [CAP_W-1:0]      cap_wdata,
	output logic [DATA_WIDTH-1:0] res_value,
	output logic [ST_W-1:0]       res_status,
	output logic [CNTO_W-1:0]     res_count
);

	op_t                   op_q;
	logic [POS_W-1:0]      pos_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [CNT_W-1:0]      count_q;
	logic [CAP_W-1:0]      cap_q;
	logic [DATA_WIDTH-1:0] entries_q [MAX_ENTRIES];
	logic [DATA_WIDTH-1:0] entries_d [MAX_ENTRIES];
	logic [DATA_WIDTH-1:0] res_value_q;
	status_t               res_status_q;
	logic [CNTO_W-1:0]     res_count_q;

	logic [CMP_W-1:0]      cnt_ext, pos_ext, cap_ext, eff_cap;
	logic                  full;
	logic                  app_ok, ins_ok, del_ok;
	logic [CNT_W-1:0]      count_d;
	status_t               status_d;
	logic [DATA_WIDTH-1:0] rd_d;

	assign cnt_ext = CMP_W'(count_q);
	assign pos_ext = CMP_W'(pos_q);
	assign cap_ext = CMP_W'(cap_q);

	always_comb begin
		if (cap_ext == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
			eff_cap = CMP_W'(MAX_ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
	end

	assign full = (cnt_ext >= eff_cap) || (cnt_ext >= CMP_W'(MAX_ENTRIES));

	// Decode the held item into status, read data and next count
	always_comb begin
		app_ok   = 1'b0;
		ins_ok   = 1'b0;
		del_ok   = 1'b0;
		count_d  = count_q;
		status_d = ST_DONE;
		rd_d     = '0;
		unique case (op_q)
			OP_APPEND: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					app_ok  = 1'b1;
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_REMOVE_LAST: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					count_d = count_q - CNT_W'(1);
				end
			end
			OP_INSERT: begin
				if (pos_ext > cnt_ext) begin
					status_d = ST_BAD_POS;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					ins_ok  = 1'b1;
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_DELETE: begin
				if (pos_ext >= cnt_ext) begin
					status_d = ST_BAD_POS;
				end else begin
					del_ok  = 1'b1;
					count_d = count_q - CNT_W'(1);
				end
			end
			OP_READ: begin
				if (pos_ext >= cnt_ext || pos_ext >= CMP_W'(MAX_ENTRIES)) begin
					status_d = ST_BAD_POS;
				end else begin
					rd_d = entries_q[pos_ext[IDX_W-1:0]];
				end
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
	end

	// Each cell picks from itself, its lower or upper neighbor, or the new value
	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		localparam int DN = (g > 0) ? g - 1 : g;
		localparam int UP = (g < MAX_ENTRIES - 1) ? g + 1 : g;
		localparam logic [CMP_W-1:0] G = CMP_W'(g);

		always_comb begin
			entries_d[g] = entries_q[g];
			if (app_ok && cnt_ext == G) begin
				entries_d[g] = val_q;
			end
			if (ins_ok) begin
				if (G > pos_ext) begin
					entries_d[g] = entries_q[DN];
				end else if (G == pos_ext) begin
					entries_d[g] = val_q;
				end
			end
			if (del_ok && G >= pos_ext && g < MAX_ENTRIES - 1) begin
				entries_d[g] = entries_q[UP];
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				entries_q[g] <= entries_d[g];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= op_t'(in_opcode);
			pos_q <= in_position;
			val_q <= in_value;
		end
		if (cmd.exec) begin
			res_value_q  <= rd_d;
			res_status_q <= status_d;
			res_count_q  <= CNTO_W'(count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= CAP_W'(MAX_ENTRIES);
		end else begin
			if (cmd.exec) begin
				count_q <= count_d;
			end
			if (cap_we) begin
				cap_q <= cap_wdata;
			end
		end
	end

	assign res_value  = res_value_q;
	assign res_status = res_status_q;
	assign res_count  = res_count_q;

endmodule

// ----- sv/bounded_ordered_list_engine.sv -----
// Top level of the bounded ordered list engine: stream ports, controller
// and datapath. Depends on boe_pkg, boe_ctrl and boe_datapath.
//
//   port group   dir  tdata (low bit up)                    tuser
//   s_axis_*     in   position[4:0], value[36:5], pad       opcode[2:0]
//   m_axis_*     out  read_value[31:0], entry_count[36:32]  status[1:0]
//   cfg_wr_*     in   capacity_limit[4:0]                   -
//
// An item is first registered in the input register, then applied to the
// entry cells, all of which shift in parallel as it is applied.
// Reset clears the count and sets the capacity to the full depth; entries
// hold unknown data until written. A stalled result holds in its register;
// the next item is taken meanwhile and waits in the input register.
module bounded_ordered_list_engine import boe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [IN_TDATA-1:0]  s_axis_tdata,   // position, value, zero pad
	input  logic [OP_W-1:0]      s_axis_tuser,   // opcode
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [OUT_TDATA-1:0] m_axis_tdata,   // read_value, entry_count, zero pad
	output logic [ST_W-1:0]      m_axis_tuser,   // status
	input  logic                 cfg_wr_en,
	input  logic [CAP_W-1:0]     cfg_wr_data
);

	boe_cmd_t              cmd;
	logic [DATA_WIDTH-1:0] res_value;
	logic [ST_W-1:0]       res_status;
	logic [CNTO_W-1:0]     res_count;

	boe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	boe_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_opcode   (s_axis_tuser),
		.in_position (s_axis_tdata[POS_W-1:0]),
		.in_value    (s_axis_tdata[POS_W+DATA_WIDTH-1:POS_W]),
		.cap_we      (cfg_wr_en),
		.cap_wdata   (cfg_wr_data),
		.res_value   (res_value),
		.res_status  (res_status),
		.res_count   (res_count)
	);

	assign m_axis_tdata = OUT_TDATA'({res_count, res_value});
	assign m_axis_tuser = res_status;

endmodule
